// ===== design/wavhp_pkg.sv =====
// shared types, codes and constants of the wav header parser
package wavhp_pkg;

  typedef enum logic [2:0] {
    PH_FILE,
    PH_CHUNK,
    PH_FMT,
    PH_FACT,
    PH_SKIP,
    PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [1:0] OUTCOME_OK          = 2'd0;
  localparam logic [1:0] OUTCOME_FORMAT      = 2'd1;
  localparam logic [1:0] OUTCOME_UNSUPPORTED = 2'd2;
  localparam logic [1:0] OUTCOME_END_EARLY   = 2'd3;

  localparam logic [1:0] CODEC_NONE  = 2'd0;
  localparam logic [1:0] CODEC_PCM   = 2'd1;
  localparam logic [1:0] CODEC_ADPCM = 2'd2;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM   = 16'h0001;
  localparam logic [15:0] FMT_ADPCM = 16'h0020;

  localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
  localparam logic [31:0] FACT_MIN_LEN = 32'd4;

  // byte index within a header or field group
  localparam logic [3:0] IDX_TAG_END    = 4'd3;
  localparam logic [3:0] IDX_CHUNK_END  = 4'd7;
  localparam logic [3:0] IDX_FILE_END   = 4'd11;
  localparam logic [3:0] IDX_FMT_TAG    = 4'd1;
  localparam logic [3:0] IDX_FMT_CHAN   = 4'd3;
  localparam logic [3:0] IDX_FMT_RATE   = 4'd7;
  localparam logic [3:0] IDX_FMT_BRATE  = 4'd11;
  localparam logic [3:0] IDX_FMT_ALIGN  = 4'd13;
  localparam logic [3:0] IDX_FMT_WIDTH  = 4'd15;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [31:0] byterate;
    logic [15:0] align;
    logic [15:0] width;
  } fmt_fields_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [1:0]  codec;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [31:0] uncompressed_size;
  } result_t;

endpackage

// ===== design/wavhp_fmt_check.sv =====
// validation of the captured fmt chunk fields
module wavhp_fmt_check (
  input  wavhp_pkg::fmt_fields_t fields,
  output logic                   ok,
  output logic [1:0]             codec
);

  logic basic_ok;
  logic pcm_width_ok;

  assign basic_ok = (fields.channels != 16'd0) && (fields.channels <= 16'd2) &&
                    (fields.align != 16'd0) && (fields.width != 16'd0) &&
                    (fields.rate != 32'd0) && (fields.byterate != 32'd0);

  assign pcm_width_ok = (fields.width == 16'd8) || (fields.width == 16'd16) ||
                        (fields.width == 16'd24) || (fields.width == 16'd32);

  always_comb begin
    ok    = 1'b0;
    codec = wavhp_pkg::CODEC_NONE;
    if (basic_ok) begin
      if (fields.tag == wavhp_pkg::FMT_PCM) begin
        ok    = pcm_width_ok;
        codec = wavhp_pkg::CODEC_PCM;
      end else if (fields.tag == wavhp_pkg::FMT_ADPCM) begin
        ok    = (fields.width == 16'd4) && (fields.channels == 16'd1);
        codec = wavhp_pkg::CODEC_ADPCM;
      end
    end
  end

endmodule

// ===== design/wavhp_out_skid.sv =====
// result register with a skid stage so the parser keeps taking bytes
module wavhp_out_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wavhp_pkg::result_t  push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output wavhp_pkg::result_t  out_data
);

  logic               skid_valid;
  wavhp_pkg::result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into a full skid stage");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled without a stalled output");

endmodule

// ===== design/wav_header_parser_unit.sv =====
// top level of the byte-serial wav header parser
//
// item channel: item_valid / item_stall carry kind and byte_value; kind 0 is a
// file byte, 1 marks end of stream, 2 restarts the parse for a new source,
// 3 is ignored. a transaction is taken when item_valid is high and
// item_stall is low.
// result channel: result_valid / result_stall carry one result per parse:
// outcome, codec, the fmt fields, data offset and sizes. on any error
// outcome is nonzero and every other field is zero.
// throughput: one transaction per cycle while item_stall is low. the parse
// state updates in the cycle a byte is taken; the transaction that causes a
// result (the data header's last size byte, an error byte, or end of stream)
// loads it into the result register, or into the skid stage on a stall.
// a result register plus a one-entry skid stage sit on the output; while the
// receiver stalls, item_stall rises only once both are full.
// reset (rst, synchronous) clears the parse state and drops any pending
// result; a restart transaction clears the parse state only.
module wav_header_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  byte_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  outcome,
  output logic [1:0]  codec,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [31:0] byte_rate,
  output logic [15:0] block_align,
  output logic [15:0] bits_per_sample,
  output logic [31:0] data_offset,
  output logic [31:0] data_size,
  output logic [31:0] uncompressed_size
);

  wavhp_pkg::phase_t phase, phase_next;
  logic [3:0]  byte_in_field, byte_in_field_next;
  logic [31:0] assemble_word, assemble_word_next;
  logic [31:0] chunk_type, chunk_type_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] skip_left, skip_left_next;
  logic [31:0] position, position_next;
  logic [15:0] format_tag, format_tag_next;
  logic [1:0]  codec_held, codec_held_next;
  logic [15:0] channels_held, channels_held_next;
  logic [31:0] rate_held, rate_held_next;
  logic [31:0] byterate_held, byterate_held_next;
  logic [15:0] align_held, align_held_next;
  logic [15:0] width_held, width_held_next;
  logic [31:0] fact_size, fact_size_next;

  logic                   accept;
  logic                   skid_full;
  logic [31:0]            shifted;
  logic [31:0]            skip_dec;
  logic                   fail_en;
  logic [1:0]             fail_code;
  logic                   push;
  wavhp_pkg::result_t     push_data;
  wavhp_pkg::result_t     out_data;
  wavhp_pkg::fmt_fields_t chk_fields;
  logic                   chk_ok;
  logic [1:0]             chk_codec;

  assign item_stall = skid_full;
  assign accept     = item_valid && !skid_full;
  assign shifted    = {byte_value, assemble_word[31:8]};
  assign skip_dec   = (skip_left != 32'd0) ? skip_left - 32'd1 : 32'd0;

  // the width arrives with the last fmt byte, everything else is already held
  assign chk_fields = '{
    tag:      format_tag,
    channels: channels_held,
    rate:     rate_held,
    byterate: byterate_held,
    align:    align_held,
    width:    (phase == wavhp_pkg::PH_FMT) ? shifted[31:16] : width_held
  };

  wavhp_fmt_check u_fmt_check (
    .fields (chk_fields),
    .ok     (chk_ok),
    .codec  (chk_codec)
  );

  always_comb begin
    phase_next         = phase;
    byte_in_field_next = byte_in_field;
    assemble_word_next = assemble_word;
    chunk_type_next    = chunk_type;
    chunk_length_next  = chunk_length;
    skip_left_next     = skip_left;
    position_next      = position;
    format_tag_next    = format_tag;
    codec_held_next    = codec_held;
    channels_held_next = channels_held;
    rate_held_next     = rate_held;
    byterate_held_next = byterate_held;
    align_held_next    = align_held;
    width_held_next    = width_held;
    fact_size_next     = fact_size;
    fail_en            = 1'b0;
    fail_code          = wavhp_pkg::OUTCOME_OK;
    push               = 1'b0;
    push_data          = '0;

    if (accept) begin
      case (kind)
        wavhp_pkg::KIND_RESTART: begin
          phase_next         = wavhp_pkg::PH_FILE;
          byte_in_field_next = '0;
          assemble_word_next = '0;
          chunk_type_next    = '0;
          chunk_length_next  = '0;
          skip_left_next     = '0;
          position_next      = '0;
          format_tag_next    = '0;
          codec_held_next    = wavhp_pkg::CODEC_NONE;
          channels_held_next = '0;
          rate_held_next     = '0;
          byterate_held_next = '0;
          align_held_next    = '0;
          width_held_next    = '0;
          fact_size_next     = '0;
        end
        wavhp_pkg::KIND_END: begin
          if (phase != wavhp_pkg::PH_DONE) begin
            fail_en   = 1'b1;
            fail_code = wavhp_pkg::OUTCOME_END_EARLY;
          end
        end
        wavhp_pkg::KIND_BYTE: begin
          if (phase != wavhp_pkg::PH_DONE) begin
            position_next      = position + 32'd1;
            assemble_word_next = shifted;
            byte_in_field_next = byte_in_field + 4'd1;
            case (phase)
              wavhp_pkg::PH_FILE: begin
                if (byte_in_field == wavhp_pkg::IDX_TAG_END) chunk_type_next = shifted;
                if (byte_in_field == wavhp_pkg::IDX_FILE_END) begin
                  if (chunk_type != wavhp_pkg::TAG_RIFF || shifted != wavhp_pkg::TAG_WAVE) begin
                    fail_en   = 1'b1;
                    fail_code = wavhp_pkg::OUTCOME_FORMAT;
                  end else begin
                    phase_next         = wavhp_pkg::PH_CHUNK;
                    byte_in_field_next = '0;
                  end
                end
              end
              wavhp_pkg::PH_CHUNK: begin
                if (byte_in_field == wavhp_pkg::IDX_TAG_END) chunk_type_next = shifted;
                if (byte_in_field == wavhp_pkg::IDX_CHUNK_END) begin
                  chunk_length_next  = shifted;
                  byte_in_field_next = '0;
                  if (chunk_type == wavhp_pkg::TAG_FMT) begin
                    if (shifted < wavhp_pkg::FMT_MIN_LEN) begin
                      fail_en   = 1'b1;
                      fail_code = wavhp_pkg::OUTCOME_FORMAT;
                    end else begin
                      phase_next = wavhp_pkg::PH_FMT;
                    end
                  end else if (chunk_type == wavhp_pkg::TAG_FACT) begin
                    if (shifted < wavhp_pkg::FACT_MIN_LEN) begin
                      fail_en   = 1'b1;
                      fail_code = wavhp_pkg::OUTCOME_FORMAT;
                    end else begin
                      phase_next = wavhp_pkg::PH_FACT;
                    end
                  end else if (chunk_type == wavhp_pkg::TAG_DATA) begin
                    if (codec_held == wavhp_pkg::CODEC_NONE) begin
                      fail_en   = 1'b1;
                      fail_code = wavhp_pkg::OUTCOME_FORMAT;
                    end else begin
                      push                        = 1'b1;
                      push_data.outcome           = wavhp_pkg::OUTCOME_OK;
                      push_data.codec             = codec_held;
                      push_data.channel_count     = channels_held;
                      push_data.sample_rate       = rate_held;
                      push_data.byte_rate         = byterate_held;
                      push_data.block_align       = align_held;
                      push_data.bits_per_sample   = width_held;
                      push_data.data_offset       = position + 32'd1;
                      push_data.data_size         = shifted;
                      push_data.uncompressed_size =
                        (codec_held == wavhp_pkg::CODEC_PCM || fact_size == 32'd0) ?
                        shifted : fact_size;
                      phase_next = wavhp_pkg::PH_DONE;
                    end
                  end else begin
                    skip_left_next = shifted;
                    phase_next     = (shifted == 32'd0) ? wavhp_pkg::PH_CHUNK :
                                                          wavhp_pkg::PH_SKIP;
                  end
                end
              end
              wavhp_pkg::PH_FMT: begin
                case (byte_in_field)
                  wavhp_pkg::IDX_FMT_TAG:   format_tag_next    = shifted[31:16];
                  wavhp_pkg::IDX_FMT_CHAN:  channels_held_next = shifted[31:16];
                  wavhp_pkg::IDX_FMT_RATE:  rate_held_next     = shifted;
                  wavhp_pkg::IDX_FMT_BRATE: byterate_held_next = shifted;
                  wavhp_pkg::IDX_FMT_ALIGN: align_held_next    = shifted[31:16];
                  wavhp_pkg::IDX_FMT_WIDTH: width_held_next    = shifted[31:16];
                  default: ;
                endcase
                if (byte_in_field == wavhp_pkg::IDX_FMT_WIDTH) begin
                  byte_in_field_next = '0;
                  if (chunk_length > wavhp_pkg::FMT_MIN_LEN) begin
                    // extension bytes are skipped before validation
                    skip_left_next = chunk_length - wavhp_pkg::FMT_MIN_LEN;
                    phase_next     = wavhp_pkg::PH_SKIP;
                  end else if (!chk_ok) begin
                    fail_en   = 1'b1;
                    fail_code = wavhp_pkg::OUTCOME_UNSUPPORTED;
                  end else begin
                    codec_held_next = chk_codec;
                    phase_next      = wavhp_pkg::PH_CHUNK;
                  end
                end
              end
              wavhp_pkg::PH_FACT: begin
                if (byte_in_field == wavhp_pkg::IDX_TAG_END) begin
                  fact_size_next     = shifted;
                  byte_in_field_next = '0;
                  if (chunk_length > wavhp_pkg::FACT_MIN_LEN) begin
                    skip_left_next = chunk_length - wavhp_pkg::FACT_MIN_LEN;
                    phase_next     = wavhp_pkg::PH_SKIP;
                  end else begin
                    phase_next = wavhp_pkg::PH_CHUNK;
                  end
                end
              end
              wavhp_pkg::PH_SKIP: begin
                byte_in_field_next = '0;
                skip_left_next     = skip_dec;
                if (skip_dec == 32'd0) begin
                  if (chunk_type == wavhp_pkg::TAG_FMT && !chk_ok) begin
                    fail_en   = 1'b1;
                    fail_code = wavhp_pkg::OUTCOME_UNSUPPORTED;
                  end else begin
                    if (chunk_type == wavhp_pkg::TAG_FMT) codec_held_next = chk_codec;
                    phase_next = wavhp_pkg::PH_CHUNK;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end

    if (fail_en) begin
      push              = 1'b1;
      push_data         = '0;
      push_data.outcome = fail_code;
      phase_next        = wavhp_pkg::PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wavhp_pkg::PH_FILE;
      byte_in_field <= '0;
      assemble_word <= '0;
      chunk_type    <= '0;
      chunk_length  <= '0;
      skip_left     <= '0;
      position      <= '0;
      format_tag    <= '0;
      codec_held    <= wavhp_pkg::CODEC_NONE;
      channels_held <= '0;
      rate_held     <= '0;
      byterate_held <= '0;
      align_held    <= '0;
      width_held    <= '0;
      fact_size     <= '0;
    end else begin
      phase         <= phase_next;
      byte_in_field <= byte_in_field_next;
      assemble_word <= assemble_word_next;
      chunk_type    <= chunk_type_next;
      chunk_length  <= chunk_length_next;
      skip_left     <= skip_left_next;
      position      <= position_next;
      format_tag    <= format_tag_next;
      codec_held    <= codec_held_next;
      channels_held <= channels_held_next;
      rate_held     <= rate_held_next;
      byterate_held <= byterate_held_next;
      align_held    <= align_held_next;
      width_held    <= width_held_next;
      fact_size     <= fact_size_next;
    end
  end

  wavhp_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (skid_full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (out_data)
  );

  assign outcome           = out_data.outcome;
  assign codec             = out_data.codec;
  assign channel_count     = out_data.channel_count;
  assign sample_rate       = out_data.sample_rate;
  assign byte_rate         = out_data.byte_rate;
  assign block_align       = out_data.block_align;
  assign bits_per_sample   = out_data.bits_per_sample;
  assign data_offset       = out_data.data_offset;
  assign data_size         = out_data.data_size;
  assign uncompressed_size = out_data.uncompressed_size;

  a_ok_has_codec: assert property (@(posedge clk) disable iff (rst)
    push && push_data.outcome == wavhp_pkg::OUTCOME_OK |->
      push_data.codec != wavhp_pkg::CODEC_NONE && push_data.channel_count != 16'd0)
    else $error("ok result without a validated codec");

  a_error_clears_fields: assert property (@(posedge clk) disable iff (rst)
    push && push_data.outcome != wavhp_pkg::OUTCOME_OK |->
      push_data.codec == wavhp_pkg::CODEC_NONE && push_data.data_size == 32'd0)
    else $error("error result carries nonzero fields");

  a_result_ends_parse: assert property (@(posedge clk) disable iff (rst)
    push |=> phase == wavhp_pkg::PH_DONE)
    else $error("parse continues after a result");

  a_done_is_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == wavhp_pkg::PH_DONE |-> !push)
    else $error("result produced after the parse ended");

endmodule
